// File: sv/mift_pkg.sv
// Package for the masked IPv4 filter table: sizes, codes, transaction types and helpers.
package mift_pkg;

  localparam int unsigned MAX_ENTRIES = 1024;
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
  localparam logic [7:0]  OCTET_ONES = 8'd255;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic             blocked;
    logic [1:0]       status;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [3:0]  en;
    logic [31:0] cmp;
  } entry_t;

  typedef struct packed {
    logic lookup_hit;
    logic free_hit;
    logic exact_hit;
  } match_t;

  // Enable an octet when the given address has it nonzero.
  function automatic logic [3:0] enables_of(logic [31:0] addr);
    logic [3:0] e;
    e = '0;
    for (int k = 0; k < 4; k++) begin
      e[k] = (addr[8*k +: 8] != 8'd0);
    end
    return e;
  endfunction

  // Widen a per-octet enable into a 32-bit mask.
  function automatic logic [31:0] expand(logic [3:0] en);
    logic [31:0] m;
    m = '0;
    for (int k = 0; k < 4; k++) begin
      m[8*k +: 8] = en[k] ? OCTET_ONES : 8'd0;
    end
    return m;
  endfunction

endpackage

// File: sv/mift_match.sv
// Shared entry compare unit: lookup, free-slot and exact matches for one table entry.
module mift_match (
  input  mift_pkg::entry_t entry_i,
  input  logic [31:0]      address_i,
  output mift_pkg::match_t match_o
);

  logic [3:0] addr_en;

  assign addr_en = mift_pkg::enables_of(address_i);

  assign match_o.lookup_hit = ((address_i & mift_pkg::expand(entry_i.en)) == entry_i.cmp);
  assign match_o.free_hit   = (entry_i.cmp == mift_pkg::ALL_ONES);
  assign match_o.exact_hit  = (entry_i.en == addr_en) && (entry_i.cmp == address_i);

endmodule

// File: sv/masked_ip_filter_table.sv
// Top level of the masked IPv4 filter table: sequencer, entry memory and result register.
// Operation: a transaction scans the entries from index 0 up to the first hit; an empty table
//   or an unused code finishes at once, and a remove that hits then moves every later entry
//   down by one slot before done_o.
// Throughput: one transaction at a time, one entry per cycle through the single read port;
//   a new start is taken in the cycle done_o is high.
// Reset: clears the entry count, sequencer and strobe, sets ban_q to 1; the entry
//   memory is not cleared. Results cannot be stalled by the receiver.
module masked_ip_filter_table (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             start_i,
  input  mift_pkg::req_t   req_i,
  output logic             busy_o,
  output logic             done_o,
  output mift_pkg::rsp_t   rsp_o
);

  localparam int unsigned IDX_W = mift_pkg::IDX_W;
  localparam int unsigned CNT_W = mift_pkg::CNT_W;

  // Sequencer and bookkeeping registers
  mift_pkg::state_e state_q, state_d;
  mift_pkg::req_t   req_q, req_d;
  logic [CNT_W-1:0] idx_q, idx_d;        // next entry to read
  logic             cmp_vld_q, cmp_vld_d; // rd_data_q holds a live entry
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d; // index of the entry in rd_data_q
  logic [CNT_W-1:0] count_q, count_d;
  logic             ban_q;
  mift_pkg::rsp_t   rsp_q, rsp_d;
  logic             done_q, done_d;

  // Entry memory: one write and one registered read per cycle
  mift_pkg::entry_t mem_q [mift_pkg::MAX_ENTRIES];
  mift_pkg::entry_t rd_data_q;
  logic             mem_re, mem_we;
  logic [IDX_W-1:0] mem_ra, mem_wa;
  mift_pkg::entry_t mem_wd;

  mift_pkg::match_t match;
  logic             accept;
  logic             more;
  logic             func_ok;
  logic             hit;
  logic             hit_found;
  logic             finish;
  logic             full;

  assign accept  = start_i && !busy_o;
  assign more    = (idx_q < count_q);
  assign full    = (count_q == CNT_W'(mift_pkg::MAX_ENTRIES));
  assign func_ok = (req_q.func == mift_pkg::FUNC_LOOKUP) ||
                   (req_q.func == mift_pkg::FUNC_ADD) ||
                   (req_q.func == mift_pkg::FUNC_REMOVE);

  mift_match u_match (
    .entry_i   (rd_data_q),
    .address_i (req_q.address),
    .match_o   (match)
  );

  // Pick the compare that this operation scans for
  always_comb begin
    case (req_q.func)
      mift_pkg::FUNC_LOOKUP: hit = match.lookup_hit;
      mift_pkg::FUNC_ADD:    hit = match.free_hit;
      mift_pkg::FUNC_REMOVE: hit = match.exact_hit;
      default:               hit = 1'b0;
    endcase
  end

  assign hit_found = cmp_vld_q && hit;
  // Stop the scan on a hit, when the table is exhausted, or at once for an unused code
  assign finish    = !func_ok || hit_found || (!cmp_vld_q && !more);

  // Next-state logic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mift_pkg::S_IDLE: begin
        if (accept) state_d = mift_pkg::S_SCAN;
      end
      mift_pkg::S_SCAN: begin
        if (finish) begin
          if (hit_found && (req_q.func == mift_pkg::FUNC_REMOVE)) begin
            state_d = mift_pkg::S_SHIFT;
          end else begin
            state_d = mift_pkg::S_IDLE;
          end
        end
      end
      mift_pkg::S_SHIFT: begin
        if (!more && !cmp_vld_q) state_d = mift_pkg::S_IDLE;
      end
      default: state_d = mift_pkg::S_IDLE;
    endcase
  end

  // Datapath and output logic
  always_comb begin
    req_d      = req_q;
    idx_d      = idx_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    count_d    = count_q;
    rsp_d      = rsp_q;
    done_d     = 1'b0;
    mem_re     = 1'b0;
    mem_ra     = idx_q[IDX_W-1:0];
    mem_we     = 1'b0;
    mem_wa     = cmp_idx_q;
    mem_wd.en  = mift_pkg::enables_of(req_q.address);
    mem_wd.cmp = req_q.address;

    unique case (state_q)
      mift_pkg::S_IDLE: begin
        // Latch the transaction and rewind the scan pointer
        if (accept) begin
          req_d = req_i;
          idx_d = '0;
        end
      end

      mift_pkg::S_SCAN: begin
        if (finish) begin
          done_d        = 1'b1;
          rsp_d.blocked = 1'b0;
          rsp_d.status  = mift_pkg::STAT_DONE;
          case (req_q.func)
            mift_pkg::FUNC_LOOKUP: begin
              rsp_d.blocked = hit_found ? ban_q : ~ban_q;
            end
            mift_pkg::FUNC_ADD: begin
              if (hit_found) begin
                // Reuse the all-ones slot
                mem_we = 1'b1;
                mem_wa = cmp_idx_q;
              end else if (full) begin
                rsp_d.status = mift_pkg::STAT_FULL;
              end else begin
                // Append behind the last entry
                mem_we  = 1'b1;
                mem_wa  = count_q[IDX_W-1:0];
                count_d = count_q + CNT_W'(1);
              end
            end
            mift_pkg::FUNC_REMOVE: begin
              if (hit_found) begin
                // Hold the result and close the gap first
                done_d = 1'b0;
                idx_d  = CNT_W'(cmp_idx_q) + CNT_W'(1);
              end else begin
                rsp_d.status = mift_pkg::STAT_NOT_FOUND;
              end
            end
            default: ;
          endcase
          rsp_d.entry_count = count_d;
        end else if (more) begin
          // Advance the read pointer; the compare sees the data in the following cycle
          mem_re    = 1'b1;
          idx_d     = idx_q + CNT_W'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[IDX_W-1:0];
        end
      end

      mift_pkg::S_SHIFT: begin
        // Move the entry read last cycle down by one slot
        if (cmp_vld_q) begin
          mem_we = 1'b1;
          mem_wa = cmp_idx_q - IDX_W'(1);
          mem_wd = rd_data_q;
        end
        if (more) begin
          mem_re    = 1'b1;
          idx_d     = idx_q + CNT_W'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[IDX_W-1:0];
        end else if (!cmp_vld_q) begin
          count_d           = count_q - CNT_W'(1);
          done_d            = 1'b1;
          rsp_d.blocked     = 1'b0;
          rsp_d.status      = mift_pkg::STAT_DONE;
          rsp_d.entry_count = count_d;
        end
      end

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mift_pkg::S_IDLE;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      count_q   <= '0;
      ban_q     <= 1'b1;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cmp_vld_q <= cmp_vld_d;
      count_q   <= count_d;
      done_q    <= done_d;
      if (cfg_we_i) ban_q <= cfg_wdata_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    cmp_idx_q <= cmp_idx_d;
    rsp_q     <= rsp_d;
  end

  // Entry memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rd_data_q <= mem_q[mem_ra];
  end

  assign busy_o = (state_q != mift_pkg::S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_done_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without a transaction in progress");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted transaction did not start the sequencer");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(mift_pkg::MAX_ENTRIES))
    else $error("entry count above table size");

  a_shift_write_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mift_pkg::S_SHIFT) && mem_we |-> (CNT_W'(mem_wa) < count_q))
    else $error("shift wrote outside the used entries");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == mift_pkg::STAT_FULL) |->
      (rsp_o.entry_count == CNT_W'(mift_pkg::MAX_ENTRIES)))
    else $error("table full reported below capacity");
`endif

endmodule
